// ===== rtl/swmf_pkg.sv =====
// ----------------------------------------------------------------------------
// Square window morphology filter: shared definitions
// Sizes, item types, register indexes and the max/min helper.
// ----------------------------------------------------------------------------
package swmf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_RADIUS = 3;

    localparam int NSLOT   = 2 * MAX_RADIUS;
    localparam int WIN     = 2 * MAX_RADIUS + 1;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int SLOT_W  = $clog2(NSLOT);
    localparam int SPAN_W  = $clog2(NSLOT + 1);
    localparam int DIM_W   = 11;
    localparam int CNT_W   = DIM_W + 1;
    localparam int WORD_W  = NSLOT * 8;
    localparam int POS_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_RADIUS * MAX_WIDTH
                                    + MAX_RADIUS + 1);

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;
    localparam logic [1:0] CFG_RADIUS = 2'd3;

    typedef struct packed {
        logic [7:0] pixel_in;
        logic       drain;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic       frame_last;
    } pix_out_t;

    typedef struct packed {
        logic              erode;
        logic [CNT_W-1:0]  w;
        logic [CNT_W-1:0]  h;
        logic [SPAN_W-1:0] r;
        logic [SPAN_W-1:0] span;
    } eff_t;

    typedef struct packed {
        logic [7:0]        pixel;
        logic              use_pixel;
        logic              wr;
        logic [COL_W-1:0]  addr;
        logic [SLOT_W-1:0] slot;
        logic [NSLOT-1:0]  smask;
        logic [WIN-1:0]    hmask;
        logic              emit;
        logic              last;
    } item_ctl_t;

    typedef struct packed {
        logic           valid;
        logic           emit;
        logic           last;
        logic [WIN-1:0] hmask;
    } c_info_t;

    function automatic logic [7:0] pick(input logic erode, input logic [7:0] a,
                                        input logic [7:0] b);
        if (erode)
            return (a < b) ? a : b;
        return (a > b) ? a : b;
    endfunction

endpackage

// ===== rtl/swmf_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; a read of the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
module swmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/swmf_scan.sv =====
// ----------------------------------------------------------------------------
// Scan position tracker
// Keeps input and output raster positions and decides, per item, which line
// slots and window columns take part and whether a result is due.
// ----------------------------------------------------------------------------
module swmf_scan
    import swmf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  eff_t      eff,
    input  logic      restart,
    input  logic      accept,
    input  pix_in_t   pix,
    output logic      take,
    output item_ctl_t ctl
);

    logic [CNT_W-1:0]  in_row_reg, in_row_next;
    logic [CNT_W-1:0]  in_col_reg, in_col_next;
    logic [CNT_W-1:0]  out_row_reg, out_row_next;
    logic [CNT_W-1:0]  out_col_reg, out_col_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  delay;
    logic              pixel_phase;

    assign pixel_phase = in_row_reg < eff.h;
    assign take        = !(pix.drain && pixel_phase);
    assign delay       = POS_W'(eff.r) * POS_W'(eff.w) + POS_W'(eff.r);

    always_comb
    begin
        logic [CNT_W-1:0] t;
        logic [CNT_W:0]   hc;
        ctl           = '0;
        ctl.pixel     = pix.pixel_in;
        ctl.use_pixel = pixel_phase;
        ctl.wr        = pixel_phase && (eff.span != '0);
        ctl.addr      = in_col_reg[COL_W-1:0];
        ctl.slot      = slot_reg;
        ctl.emit      = pos_reg >= delay;
        ctl.last      = ctl.emit && (out_row_reg + 1'b1 >= eff.h)
                        && (out_col_reg + 1'b1 >= eff.w);
        // Slot s holds the row t lines above the current one.
        for (int s = 0; s < NSLOT; s++)
        begin
            if (CNT_W'(slot_reg) > CNT_W'(s))
                t = CNT_W'(slot_reg) - CNT_W'(s);
            else
                t = CNT_W'(slot_reg) + CNT_W'(eff.span) - CNT_W'(s);
            ctl.smask[s] = (CNT_W'(s) < CNT_W'(eff.span)) && (t <= in_row_reg)
                           && ((in_row_reg - t) < eff.h);
        end
        hc = (CNT_W + 1)'(out_col_reg) + (CNT_W + 1)'(eff.r);
        for (int a = 0; a < WIN; a++)
        begin
            ctl.hmask[a] = (SPAN_W'(a) <= eff.span) && (hc >= (CNT_W + 1)'(a))
                           && ((hc - (CNT_W + 1)'(a)) < (CNT_W + 1)'(eff.w));
        end
    end

    always_comb
    begin
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        slot_next    = slot_reg;
        pos_next     = pos_reg;
        if (restart)
        begin
            in_row_next  = '0;
            in_col_next  = '0;
            out_row_next = '0;
            out_col_next = '0;
            slot_next    = '0;
            pos_next     = '0;
        end
        else if (accept && take)
        begin
            pos_next = pos_reg + 1'b1;
            if (in_col_reg + 1'b1 >= eff.w)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + 1'b1;
                if (SPAN_W'(slot_reg) + 1'b1 >= eff.span)
                    slot_next = '0;
                else
                    slot_next = slot_reg + 1'b1;
            end
            else
            begin
                in_col_next = in_col_reg + 1'b1;
            end
            if (ctl.last)
            begin
                in_row_next  = '0;
                in_col_next  = '0;
                out_row_next = '0;
                out_col_next = '0;
                slot_next    = '0;
                pos_next     = '0;
            end
            else if (ctl.emit)
            begin
                if (out_col_reg + 1'b1 >= eff.w)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + 1'b1;
                end
                else
                begin
                    out_col_next = out_col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            slot_reg    <= '0;
            pos_reg     <= '0;
        end
        else
        begin
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
            slot_reg    <= slot_next;
            pos_reg     <= pos_next;
        end
    end

    // The input column never runs past the row end.
    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        in_col_reg < eff.w)
        else $error("input column beyond row width");

    // The last result of a frame returns the scan to the origin.
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && take && ctl.last && !restart |=> (pos_reg == '0) && (in_row_reg == '0))
        else $error("scan did not restart after last result");

endmodule

// ===== rtl/swmf_column.sv =====
// ----------------------------------------------------------------------------
// Column reduction stage
// Reads the line memory word of the column, folds the stored rows and the
// new pixel into one column value, writes the pixel back and shifts the
// column value into the window registers.
// ----------------------------------------------------------------------------
module swmf_column
    import swmf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 a_valid,
    input  item_ctl_t            a_ctl,
    input  logic                 erode,
    output logic [WIN-1:0][7:0]  win,
    output c_info_t              c_info
);

    logic               b_valid_reg;
    item_ctl_t          b_ctl_reg;
    logic               b_fwd_reg;
    logic [WORD_W-1:0]  fwd_data_reg;
    logic [WORD_W-1:0]  ram_rdata;
    logic [WORD_W-1:0]  word;
    logic [WORD_W-1:0]  wdata;
    logic               we;
    logic [7:0]         acc;
    logic [WIN-1:0][7:0] win_reg;
    logic               c_valid_reg;
    logic               c_emit_reg;
    logic               c_last_reg;
    logic [WIN-1:0]     c_hmask_reg;

    swmf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (we),
        .waddr (b_ctl_reg.addr),
        .wdata (wdata),
        .re    (a_valid),
        .raddr (a_ctl.addr),
        .rdata (ram_rdata)
    );

    // With one-pixel rows, consecutive items hit the same word.
    assign word = b_fwd_reg ? fwd_data_reg : ram_rdata;
    assign we   = adv && b_valid_reg && b_ctl_reg.wr;

    always_comb
    begin
        acc = erode ? 8'hFF : 8'h00;
        if (b_ctl_reg.use_pixel)
            acc = pick(erode, acc, b_ctl_reg.pixel);
        for (int s = 0; s < NSLOT; s++)
        begin
            if (b_ctl_reg.smask[s])
                acc = pick(erode, acc, word[s*8 +: 8]);
        end
        wdata = word;
        wdata[b_ctl_reg.slot*8 +: 8] = b_ctl_reg.pixel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            b_fwd_reg   <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg <= a_valid;
            b_fwd_reg   <= we && (b_ctl_reg.addr == a_ctl.addr);
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_ctl_reg <= a_ctl;
            if (we)
                fwd_data_reg <= wdata;
            c_emit_reg  <= b_ctl_reg.emit;
            c_last_reg  <= b_ctl_reg.last;
            c_hmask_reg <= b_ctl_reg.hmask;
            if (b_valid_reg)
            begin
                for (int a = WIN - 1; a > 0; a--)
                    win_reg[a] <= win_reg[a-1];
                win_reg[0] <= acc;
            end
        end
    end

    assign win    = win_reg;
    assign c_info = {c_valid_reg, c_emit_reg, c_last_reg, c_hmask_reg};

    // A read colliding with the write of the same word must take the bypass.
    a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
        we && a_valid && (b_ctl_reg.addr == a_ctl.addr) |=> b_fwd_reg)
        else $error("line memory collision without bypass");

endmodule

// ===== rtl/square_window_morphology_filter.sv =====
// Pipeline: the item that completes a window passes the b and c registers into the output
// register, held by any stall; results trail the input by radius*width+radius items.
// Throughput: one item per cycle unless a result stalls, set by the single read and write port of the line memory.
// Reset: configuration returns to dilation, 640x480, radius 1, and the scan to the origin.
// The line memory (1024 words of six pixels) is not cleared; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Square window morphology filter
// Grayscale dilation or erosion over a square window on a raster pixel stream.
// ----------------------------------------------------------------------------
module square_window_morphology_filter
    import swmf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pix_valid,
    output logic             pix_stall,
    input  pix_in_t          pix,
    output logic             res_valid,
    input  logic             res_stall,
    output pix_out_t         res,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [DIM_W-1:0] cfg_data
);

    logic             mode_reg;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [1:0]       radius_reg;
    eff_t             eff;
    logic             cfg_we;
    logic             adv;
    logic             accept;
    logic             take;
    item_ctl_t        a_ctl;
    logic [WIN-1:0][7:0] win;
    c_info_t          c_info;
    logic [7:0]       hres;
    logic             res_valid_reg;
    pix_out_t         res_reg;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            width_reg  <= DIM_W'(640);
            height_reg <= DIM_W'(480);
            radius_reg <= 2'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:   mode_reg   <= cfg_data[0];
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                CFG_RADIUS: radius_reg <= cfg_data[1:0];
                default:    mode_reg   <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        eff.erode = mode_reg;
        if (width_reg == '0)
            eff.w = CNT_W'(1);
        else if (CNT_W'(width_reg) > CNT_W'(MAX_WIDTH))
            eff.w = CNT_W'(MAX_WIDTH);
        else
            eff.w = CNT_W'(width_reg);
        if (height_reg == '0)
            eff.h = CNT_W'(1);
        else if (CNT_W'(height_reg) > CNT_W'(MAX_HEIGHT))
            eff.h = CNT_W'(MAX_HEIGHT);
        else
            eff.h = CNT_W'(height_reg);
        if (SPAN_W'(radius_reg) > SPAN_W'(MAX_RADIUS))
            eff.r = SPAN_W'(MAX_RADIUS);
        else
            eff.r = SPAN_W'(radius_reg);
        eff.span = SPAN_W'(eff.r << 1);
    end

    assign adv       = !(res_valid_reg && res_stall);
    assign pix_stall = !adv;
    assign accept    = pix_valid && adv;

    swmf_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .eff     (eff),
        .restart (cfg_we),
        .accept  (accept),
        .pix     (pix),
        .take    (take),
        .ctl     (a_ctl)
    );

    swmf_column u_column (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .a_valid (accept && take),
        .a_ctl   (a_ctl),
        .erode   (mode_reg),
        .win     (win),
        .c_info  (c_info)
    );

    // Horizontal fold over the window columns that lie inside the row.
    always_comb
    begin
        hres = mode_reg ? 8'hFF : 8'h00;
        for (int a = 0; a < WIN; a++)
        begin
            if (c_info.hmask[a])
                hres = pick(mode_reg, hres, win[a]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (adv)
            res_valid_reg <= c_info.valid && c_info.emit;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg.pixel_out  <= hres;
            res_reg.frame_last <= c_info.last;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // A stalled result blocks the input side in the same cycle.
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |-> pix_stall)
        else $error("input accepted while result stalled");

endmodule

// ===== verif/square_window_morphology_filter_tb.sv =====
// ----------------------------------------------------------------------------
// Square window morphology filter testbench
// Drives raster frames through the filter under many register settings and
// random handshake pressure. A scoreboard predicts every result and checks it.
// ----------------------------------------------------------------------------
module square_window_morphology_filter_tb
    import swmf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3000000;

    class morph_scoreboard;
        logic              erode;
        logic [DIM_W-1:0]  width_reg;
        logic [DIM_W-1:0]  height_reg;
        logic [1:0]        radius_reg;
        logic [7:0]        line_rows [2*MAX_RADIUS*MAX_WIDTH];
        logic [7:0]        col_hist [WIN];
        int unsigned       in_row, in_col, out_row, out_col;
        pix_out_t          pending [$];
        int                errors;
        int                checked;

        function new();
            erode = 1'b0;
            width_reg = DIM_W'(640);
            height_reg = DIM_W'(480);
            radius_reg = 2'd1;
            foreach (col_hist[i]) col_hist[i] = 8'd0;
            errors = 0;
            checked = 0;
            restart();
        endfunction

        function void restart();
            in_row = 0;
            in_col = 0;
            out_row = 0;
            out_col = 0;
        endfunction

        function int unsigned eff_w();
            if (width_reg == 0) return 1;
            if (width_reg > MAX_WIDTH) return MAX_WIDTH;
            return 32'(width_reg);
        endfunction

        function int unsigned eff_h();
            if (height_reg == 0) return 1;
            if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
            return 32'(height_reg);
        endfunction

        function int unsigned eff_r();
            if (radius_reg > MAX_RADIUS) return MAX_RADIUS;
            return 32'(radius_reg);
        endfunction

        function logic [7:0] merge(logic [7:0] a, logic [7:0] b);
            if (erode) return (a < b) ? a : b;
            return (a > b) ? a : b;
        endfunction

        function void write_reg(logic [1:0] idx, logic [DIM_W-1:0] val);
            case (idx)
                CFG_MODE:   erode = val[0];
                CFG_WIDTH:  width_reg = val;
                CFG_HEIGHT: height_reg = val;
                CFG_RADIUS: radius_reg = val[1:0];
                default: ;
            endcase
            restart();
        endfunction

        // Works out the result, if any, that an accepted item causes.
        function void note_input(pix_in_t it);
            int unsigned w, h, r, span, pos, lag, t, k, addr, a, col;
            bit          in_frame;
            logic [7:0]  neutral, acc, outv;
            pix_out_t    o;
            w = eff_w();
            h = eff_h();
            r = eff_r();
            span = 2 * r;
            pos = in_row * w + in_col;
            lag = r * w + r;
            in_frame = in_row < h;
            neutral = erode ? 8'hff : 8'h00;
            acc = neutral;
            if (it.drain && in_frame) return;
            if (in_frame) acc = merge(acc, it.pixel_in);
            for (t = 1; t <= span; t++) begin
                if (t <= in_row) begin
                    k = in_row - t;
                    if (k < h) begin
                        addr = (k % span) * MAX_WIDTH + in_col;
                        if (addr < 2 * MAX_RADIUS * MAX_WIDTH)
                            acc = merge(acc, line_rows[addr]);
                    end
                end
            end
            if (in_frame && span > 0) begin
                addr = (in_row % span) * MAX_WIDTH + in_col;
                if (addr < 2 * MAX_RADIUS * MAX_WIDTH) line_rows[addr] = it.pixel_in;
            end
            for (a = WIN - 1; a > 0; a--) col_hist[a] = col_hist[a-1];
            col_hist[0] = acc;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
            if (pos < lag) return;
            outv = neutral;
            for (a = 0; a <= span; a++) begin
                col = out_col + r;
                if (col >= a) begin
                    col -= a;
                    if (col < w) outv = merge(outv, col_hist[a]);
                end
            end
            o.pixel_out = outv;
            o.frame_last = (out_row + 1 >= h) && (out_col + 1 >= w);
            pending.push_back(o);
            if (o.frame_last) restart();
            else begin
                out_col++;
                if (out_col >= w) begin
                    out_col = 0;
                    out_row++;
                end
            end
        endfunction

        function void check(pix_out_t got);
            pix_out_t exp_item;
            checked++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result pixel_out=%0d frame_last=%0d",
                         $realtime, got.pixel_out, got.frame_last);
                errors++;
                return;
            end
            exp_item = pending.pop_front();
            if (got.pixel_out !== exp_item.pixel_out) begin
                $display("%0t: pixel_out expected %0d actual %0d", $realtime,
                         exp_item.pixel_out, got.pixel_out);
                errors++;
            end
            if (got.frame_last !== exp_item.frame_last) begin
                $display("%0t: frame_last expected %0d actual %0d", $realtime,
                         exp_item.frame_last, got.frame_last);
                errors++;
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             pix_valid = 1'b0;
    logic             pix_stall;
    pix_in_t          pix = '0;
    logic             res_valid;
    logic             res_stall = 1'b0;
    pix_out_t         res;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [1:0]       cfg_index = CFG_MODE;
    logic [DIM_W-1:0] cfg_data = '0;

    morph_scoreboard sb = new();
    int  cycles = 0;
    int  burst_left = 0;
    bit  gaps_on = 1'b1;
    int  stall_style = 0;
    int  pixels_sent = 0;
    int  frames_done = 0;

    square_window_morphology_filter dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** square_window_morphology_filter: FAILED **");
            $finish;
        end
    end

    // The receiver periodically redraws its stall habit: none, sparse or dense random, or a fixed pattern.
    always @(posedge clk)
    begin
        if (cycles % 300 == 0) stall_style = $urandom_range(0, 3);
        case (stall_style)
            0: res_stall <= 1'b0;
            1: res_stall <= ($urandom_range(0, 3) == 0);
            2: res_stall <= (cycles % 9) < 4;
            default: res_stall <= ($urandom_range(0, 1) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall) sb.check(res);
    end

    task automatic send_item(input logic [7:0] p, input logic d);
        pix_in_t it;
        it.pixel_in = p;
        it.drain = d;
        if (gaps_on && burst_left == 0) begin
            pix_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        pix_valid <= 1'b1;
        pix <= it;
        do @(posedge clk); while (pix_stall);
        sb.note_input(it);
        if (burst_left > 0) burst_left--;
        if (!d) pixels_sent++;
    endtask

    // Waits until every expected item has arrived and the pipeline is quiet.
    task automatic settle();
        pix_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [DIM_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_all(input logic erode, input int w, input int h, input int r);
        write_reg(CFG_MODE, DIM_W'(erode));
        write_reg(CFG_WIDTH, DIM_W'(w));
        write_reg(CFG_HEIGHT, DIM_W'(h));
        write_reg(CFG_RADIUS, DIM_W'(r));
    endtask

    function automatic logic [7:0] any_pixel();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One frame at the current setting; a cut frame stops partway through.
    task automatic run_frame(input bit noisy, input bit cut);
        int n, flush, stop;
        n = int'(sb.eff_w() * sb.eff_h());
        flush = int'(sb.eff_r() * sb.eff_w() + sb.eff_r());
        stop = cut ? int'($urandom_range(1, n)) : n;
        for (int i = 0; i < stop; i++) begin
            if (noisy && $urandom_range(0, 9) == 0) send_item(any_pixel(), 1'b1);
            send_item(any_pixel(), 1'b0);
        end
        if (!cut) begin
            for (int i = 0; i < flush; i++) begin
                if (noisy && $urandom_range(0, 3) == 0) send_item(any_pixel(), 1'b0);
                else send_item(8'($urandom_range(0, 255)), 1'b1);
            end
            frames_done++;
        end
        settle();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: tiny frames in both modes, radius zero, zero sizes.
        set_all(1'b0, 3, 2, 1);
        send_item(8'h00, 1'b1);
        send_item(8'hff, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'haa, 1'b0);
        send_item(8'h55, 1'b1);
        send_item(8'h01, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'h7f, 1'b0);
        repeat (4) send_item(8'hff, 1'b1);
        settle();
        write_reg(CFG_MODE, DIM_W'(1));
        run_frame(1'b0, 1'b0);
        set_all(1'b1, 0, 0, 0);
        run_frame(1'b0, 1'b0);
        set_all(1'b0, 2, 2, 3);
        run_frame(1'b0, 1'b0);

        while (pixels_sent < 1100) begin
            gaps_on = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 2) == 0)
                set_all(1'($urandom_range(0, 1)), int'($urandom_range(1, 14)),
                        int'($urandom_range(1, 9)), int'($urandom_range(0, 3)));
            else
                write_reg(2'($urandom_range(0, 3)), DIM_W'($urandom_range(0, 9)));
            if (sb.eff_w() * sb.eff_h() > 200)
                write_reg(CFG_HEIGHT, DIM_W'($urandom_range(1, 6)));
            run_frame($urandom_range(0, 3) == 0, $urandom_range(0, 9) == 0);
        end

        settle();
        $display("Covered %0d complete frames and %0d results checked", frames_done,
                 sb.checked);
        $display("over dilation and erosion, radius 0 to 3, and zero to mid-sized frames.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("** square_window_morphology_filter: PASSED **");
        else
            $display("** square_window_morphology_filter: FAILED **");
        $finish;
    end

endmodule

// ===== square_window_morphology_filter.f =====
rtl/swmf_pkg.sv
rtl/swmf_ram.sv
rtl/swmf_scan.sv
rtl/swmf_column.sv
rtl/square_window_morphology_filter.sv
verif/square_window_morphology_filter_tb.sv
